// ===== hw/rtl/dat_pkg.sv =====
package dat_pkg;

    localparam int FIELD_W = 12;
    localparam int NODE_W  = 13;
    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;
    localparam int CMP_W   = 32;

    localparam logic [NODE_W-1:0]  ROOT_NODE = NODE_W'(1);
    localparam logic [COUNT_W-1:0] COUNT_SAT = COUNT_W'(127);

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_KEY   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CHECK,
        ST_FINISH
    } walk_state_t;

    typedef struct packed {
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] check;
        logic [VALUE_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic               valid;
        logic               found;
        logic [VALUE_W-1:0] value;
    } result_t;

endpackage

// ===== hw/rtl/dat_node_mem.sv =====
module dat_node_mem import dat_pkg::*; #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] addr,
    input  entry_t        wr_data,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Single port, read-first; the read data is registered.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        rd_data_reg <= mem[addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/dat_walker.sv =====
module dat_walker import dat_pkg::*; #(
    parameter int NODE_DEPTH = 4096,
    parameter int KEY_MAX    = 64,
    parameter int AW         = 12
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [NODE_W-1:0]  cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic [FIELD_W-1:0] s_entry_index,
    input  logic [FIELD_W-1:0] s_entry_base,
    input  logic [FIELD_W-1:0] s_entry_check,
    input  logic [VALUE_W-1:0] s_entry_value,
    input  logic [BYTE_W-1:0]  s_key_byte,
    input  logic               s_key_last,
    input  logic               res_room,
    output result_t            res,
    output logic               mem_wr_en,
    output logic [AW-1:0]      mem_addr,
    output entry_t             mem_wr_data,
    input  entry_t             mem_rd_data
);

    function automatic logic [AW-1:0] to_addr(input logic [NODE_W-1:0] v);
        logic [AW+NODE_W-1:0] wide;
        wide = {{AW{1'b0}}, v};
        return wide[AW-1:0];
    endfunction

    walk_state_t        state_reg, state_next;
    logic [NODE_W-1:0]  node_count_reg;
    logic [NODE_W-1:0]  cur_reg, cur_next;
    logic [NODE_W-1:0]  child_reg, child_next;
    logic               missed_reg, missed_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               cache_ok_reg, cache_ok_next;
    logic [FIELD_W-1:0] base_cache_reg, base_cache_next;
    logic [VALUE_W-1:0] value_cache_reg, value_cache_next;
    logic [BYTE_W-1:0]  byte_reg, byte_next;
    logic               last_reg, last_next;

    logic               accept;
    logic               wr_ok;
    logic [COUNT_W-1:0] count_inc;
    logic               len_miss;
    logic [FIELD_W-1:0] base_sel;
    logic [BYTE_W-1:0]  byte_sel;
    logic [NODE_W-1:0]  child;
    logic               child_ok;
    logic               check_hit;
    logic               key_acc;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign key_acc = accept && (s_kind == KIND_KEY);

    always_comb begin
        wr_ok     = {{(CMP_W-FIELD_W){1'b0}}, s_entry_index} < CMP_W'(NODE_DEPTH);
        count_inc = (count_reg < COUNT_SAT) ? count_reg + COUNT_W'(1) : count_reg;
        len_miss  = count_inc > COUNT_W'(KEY_MAX);
        base_sel  = (state_reg == ST_LOAD) ? mem_rd_data.base : base_cache_reg;
        byte_sel  = (state_reg == ST_LOAD) ? byte_reg : s_key_byte;
        child     = {1'b0, base_sel} + {{(NODE_W-BYTE_W){1'b0}}, byte_sel};
        child_ok  = (child < node_count_reg)
                 && ({{(CMP_W-NODE_W){1'b0}}, child} < CMP_W'(NODE_DEPTH));
        check_hit = {1'b0, mem_rd_data.check} == cur_reg;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (key_acc) begin
                    if (missed_reg || len_miss || (cache_ok_reg && !child_ok)) begin
                        state_next = s_key_last ? ST_FINISH : ST_IDLE;
                    end else if (!cache_ok_reg) begin
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_LOAD: begin
                if (child_ok) begin
                    state_next = ST_CHECK;
                end else begin
                    state_next = last_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_CHECK: begin
                state_next = last_reg ? ST_FINISH : ST_IDLE;
            end
            ST_FINISH: begin
                if (res_room) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory port and result.
    always_comb begin
        cur_next         = cur_reg;
        child_next       = child_reg;
        missed_next      = missed_reg;
        count_next       = count_reg;
        cache_ok_next    = cache_ok_reg;
        base_cache_next  = base_cache_reg;
        value_cache_next = value_cache_reg;
        byte_next        = byte_reg;
        last_next        = last_reg;
        mem_wr_en        = 1'b0;
        mem_addr         = to_addr(cur_reg);
        mem_wr_data      = '{base: s_entry_base, check: s_entry_check, value: s_entry_value};
        res              = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_kind == KIND_WRITE)) begin
                    mem_wr_en = wr_ok;
                    mem_addr  = to_addr({1'b0, s_entry_index});
                    // A write to the node the walk stands on refreshes the cached copy.
                    if (wr_ok && ({1'b0, s_entry_index} == cur_reg)) begin
                        cache_ok_next    = 1'b1;
                        base_cache_next  = s_entry_base;
                        value_cache_next = s_entry_value;
                    end
                end else if (key_acc) begin
                    count_next = count_inc;
                    byte_next  = s_key_byte;
                    last_next  = s_key_last;
                    if (missed_reg || len_miss || (cache_ok_reg && !child_ok)) begin
                        missed_next = 1'b1;
                    end else if (!cache_ok_reg) begin
                        mem_addr = to_addr(cur_reg);
                    end else begin
                        mem_addr   = to_addr(child);
                        child_next = child;
                    end
                end
            end
            ST_LOAD: begin
                cache_ok_next    = 1'b1;
                base_cache_next  = mem_rd_data.base;
                value_cache_next = mem_rd_data.value;
                if (child_ok) begin
                    mem_addr   = to_addr(child);
                    child_next = child;
                end else begin
                    missed_next = 1'b1;
                end
            end
            ST_CHECK: begin
                if (check_hit) begin
                    cur_next         = child_reg;
                    cache_ok_next    = 1'b1;
                    base_cache_next  = mem_rd_data.base;
                    value_cache_next = mem_rd_data.value;
                end else begin
                    missed_next = 1'b1;
                end
            end
            ST_FINISH: begin
                if (res_room) begin
                    res.valid     = 1'b1;
                    res.found     = !missed_reg;
                    res.value     = missed_reg ? '0 : value_cache_reg;
                    cur_next      = ROOT_NODE;
                    missed_next   = 1'b0;
                    count_next    = '0;
                    cache_ok_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            node_count_reg <= '0;
            cur_reg        <= ROOT_NODE;
            missed_reg     <= 1'b0;
            count_reg      <= '0;
            cache_ok_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            missed_reg   <= missed_next;
            count_reg    <= count_next;
            cache_ok_reg <= cache_ok_next;
            if (cfg_wr_en) begin
                node_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        child_reg       <= child_next;
        base_cache_reg  <= base_cache_next;
        value_cache_reg <= value_cache_next;
        byte_reg        <= byte_next;
        last_reg        <= last_next;
    end

endmodule

// ===== hw/rtl/double_array_trie_lookup.sv =====
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    kind, entry_index/base/check/value, key_byte, key_last
// m_        out        m_valid/m_ready    found, found_value
// cfg_      in         cfg_wr_en          cfg_wr_data (node_count)
//
// A write transaction is done as it is accepted. A key byte issues a node table read of the
// child, whose check decides the edge in ST_CHECK; the first byte after a restart fetches the
// root entry first, in ST_LOAD. A byte after a miss is absorbed without a table read. The
// last byte then waits in ST_FINISH to hand its result to the output register.
// Synchronous active-low reset returns the walk to the root; table contents persist.
// A result waiting on m_ready stalls only the next key's last byte.
module double_array_trie_lookup import dat_pkg::*; #(
    parameter int NODE_DEPTH = 4096,
    parameter int KEY_MAX    = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [NODE_W-1:0]  cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic [FIELD_W-1:0] s_entry_index,
    input  logic [FIELD_W-1:0] s_entry_base,
    input  logic [FIELD_W-1:0] s_entry_check,
    input  logic [VALUE_W-1:0] s_entry_value,
    input  logic [BYTE_W-1:0]  s_key_byte,
    input  logic               s_key_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_found,
    output logic [VALUE_W-1:0] m_found_value
);

    localparam int AW = $clog2(NODE_DEPTH);

    logic               mem_wr_en;
    logic [AW-1:0]      mem_addr;
    entry_t             mem_wr_data;
    entry_t             mem_rd_data;
    result_t            res;
    logic               res_room;

    logic               m_valid_reg;
    logic               m_found_reg;
    logic [VALUE_W-1:0] m_found_value_reg;

    dat_node_mem #(
        .DEPTH (NODE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .addr    (mem_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    dat_walker #(
        .NODE_DEPTH (NODE_DEPTH),
        .KEY_MAX    (KEY_MAX),
        .AW         (AW)
    ) u_walker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_entry_index (s_entry_index),
        .s_entry_base  (s_entry_base),
        .s_entry_check (s_entry_check),
        .s_entry_value (s_entry_value),
        .s_key_byte    (s_key_byte),
        .s_key_last    (s_key_last),
        .res_room      (res_room),
        .res           (res),
        .mem_wr_en     (mem_wr_en),
        .mem_addr      (mem_addr),
        .mem_wr_data   (mem_wr_data),
        .mem_rd_data   (mem_rd_data)
    );

    assign res_room = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            m_found_reg       <= res.found;
            m_found_value_reg <= res.value;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_found_value = m_found_value_reg;

endmodule
